[design/csp_pkg.sv]
// Shared types and constants for the cascade position/speed controller.
// Used by csp_ctrl, csp_datapath and cascade_position_speed_pid_top.
package csp_pkg;

   localparam int POS_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int GAIN_W   = 16;
   localparam int LIM_W    = 8;
   localparam int SPEED_W  = 16;
   localparam int ERR_W    = SPEED_W + 1;
   localparam int DERR_W   = ERR_W + 1;
   localparam int INTEG_W  = 25;
   localparam int CMD_W    = 9;
   localparam int MUL_A_W  = GAIN_W + 1;
   localparam int MUL_B_W  = POS_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int GAIN_SH  = 8;
   localparam int SCALE_SH = FRAC_W + GAIN_SH;
   localparam int DIVR_W   = ERR_W;
   localparam int MAG5_W   = DIVR_W + 3;
   localparam int QUOT_W   = FRAC_W + 3;
   localparam int INC_W    = QUOT_W + 1;
   localparam int CNT_W    = 5;
   localparam int DIV_STEPS = QUOT_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = GAIN_W;
   localparam int REQ_W      = 2 * POS_W + SPEED_W;
   localparam int RSP_W      = 32;

   localparam logic [GAIN_W-1:0] OUTER_KP_RST = 16'd77;
   localparam logic [GAIN_W-1:0] OUTER_KD_RST = 16'd102;
   localparam logic [GAIN_W-1:0] INNER_KP_RST = 16'd77;
   localparam logic [GAIN_W-1:0] INNER_KI_RST = 16'd77;
   localparam logic [GAIN_W-1:0] INNER_KD_RST = 16'd0;
   localparam logic [LIM_W-1:0]  INTEG_LIM_RST = 8'd10;
   localparam logic [LIM_W-1:0]  OUT_LIM_RST   = 8'd20;

   localparam logic signed [ACC_W-1:0] ST_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] ST_LO = ACC_W'(-32768);
   localparam logic [DIVR_W-1:0] DIV_OFFSET = DIVR_W'(5);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OUTER_KP       = 3'd0,
      REG_OUTER_KD       = 3'd1,
      REG_INNER_KP       = 3'd2,
      REG_INNER_KI       = 3'd3,
      REG_INNER_KD       = 3'd4,
      REG_INTEGRAL_LIMIT = 3'd5,
      REG_OUTPUT_LIMIT   = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_OUT_P,
      S_OUT_D,
      S_OUT_SUM,
      S_ST,
      S_ES,
      S_DS,
      S_DIV_INIT,
      S_DIV,
      S_INC,
      S_INTEG,
      S_IN_P,
      S_IN_D,
      S_IN_I,
      S_IN_SUM,
      S_CLAMP,
      S_CMD,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_OUT_KP,
      MUL_OUT_KD,
      MUL_IN_KP,
      MUL_IN_KD,
      MUL_IN_KI
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_CLAMP
   } acc_op_type;

   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        acc_shift;
      logic        dp_update;
      logic        st_update;
      logic        es_update;
      logic        ds_update;
      logic        div_init;
      logic        div_step;
      logic        inc_update;
      logic        integ_update;
      logic        cmd_update;
      logic        out_load;
   } ctrl_cmd_type;

endpackage

[design/csp_ctrl.sv]
// Sequencer for the cascade controller: steps the shared multiplier,
// accumulator and serial divider in csp_datapath. Depends on csp_pkg.
module csp_ctrl import csp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output ctrl_cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_OUT_P;
         S_OUT_P:    state_in = S_OUT_D;
         S_OUT_D:    state_in = S_OUT_SUM;
         S_OUT_SUM:  state_in = S_ST;
         S_ST:       state_in = S_ES;
         S_ES:       state_in = S_DS;
         S_DS:       state_in = S_DIV_INIT;
         S_DIV_INIT: state_in = S_DIV;
         S_DIV:      if (div_cnt_ff == '0) state_in = S_INC;
         S_INC:      state_in = S_INTEG;
         S_INTEG:    state_in = S_IN_P;
         S_IN_P:     state_in = S_IN_D;
         S_IN_D:     state_in = S_IN_I;
         S_IN_I:     state_in = S_IN_SUM;
         S_IN_SUM:   state_in = S_CLAMP;
         S_CLAMP:    state_in = S_CMD;
         S_CMD:      state_in = S_DONE;
         S_DONE:     if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      div_cnt_in = div_cnt_ff;
      if (state_ff == S_DIV_INIT) begin
         div_cnt_in = CNT_W'(DIV_STEPS - 1);
      end else if (state_ff == S_DIV) begin
         div_cnt_in = div_cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_OUT_P: begin
            cmd.mul_sel   = MUL_OUT_KP;
            cmd.dp_update = 1'b1;
         end
         S_OUT_D: begin
            cmd.mul_sel = MUL_OUT_KD;
            cmd.acc_op  = ACC_LOAD;
         end
         S_OUT_SUM:  cmd.acc_op = ACC_ADD;
         S_ST:       cmd.st_update = 1'b1;
         S_ES:       cmd.es_update = 1'b1;
         S_DS:       cmd.ds_update = 1'b1;
         S_DIV_INIT: cmd.div_init = 1'b1;
         S_DIV:      cmd.div_step = 1'b1;
         S_INC:      cmd.inc_update = 1'b1;
         S_INTEG:    cmd.integ_update = 1'b1;
         S_IN_P:     cmd.mul_sel = MUL_IN_KP;
         S_IN_D: begin
            cmd.mul_sel   = MUL_IN_KD;
            cmd.acc_op    = ACC_LOAD;
            cmd.acc_shift = 1'b1;
         end
         S_IN_I: begin
            cmd.mul_sel   = MUL_IN_KI;
            cmd.acc_op    = ACC_ADD;
            cmd.acc_shift = 1'b1;
         end
         S_IN_SUM:   cmd.acc_op = ACC_ADD;
         S_CLAMP:    cmd.acc_op = ACC_CLAMP;
         S_CMD:      cmd.cmd_update = 1'b1;
         S_DONE:     cmd.out_load = out_free;
         default:    cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_OUT_P)
      else $error("accepted transfer did not start the outer loop");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && div_cnt_ff == '0 |=> state_ff == S_INC)
      else $error("divider did not finish after its last step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_tready |=> state_ff == S_DONE)
      else $error("new result overwrote one still waiting");

endmodule

[design/csp_datapath.sv]
// Datapath for the cascade controller: config registers, loop state, shared
// multiplier, accumulator and restoring divider. Depends on csp_pkg.
module csp_datapath import csp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  ctrl_cmd_type                 cmd,
   input  logic signed [POS_W-1:0]      goal_position,
   input  logic signed [POS_W-1:0]      measured_position,
   input  logic signed [SPEED_W-1:0]    measured_speed,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   output logic signed [SPEED_W-1:0]    speed_target,
   output logic signed [CMD_W-1:0]      speed_command
);

   logic [GAIN_W-1:0] outer_kp_ff, outer_kd_ff, inner_kp_ff, inner_ki_ff, inner_kd_ff;
   logic [LIM_W-1:0]  integ_lim_ff, out_lim_ff;

   logic signed [POS_W-1:0]   ep_ff, ep_in, oprev_ff;
   logic signed [POS_W:0]     dp_ff, dp_in;
   logic signed [SPEED_W-1:0] ms_ff;
   logic signed [SPEED_W-1:0] st_ff, st_in;
   logic signed [ERR_W-1:0]   es_ff, es_in, iprev_ff;
   logic signed [DERR_W-1:0]  ds_ff, ds_in;
   logic [DIVR_W-1:0]         mag_ff, mag_in;
   logic                      neg_ff;
   logic [MAG5_W-1:0]         mag5;
   logic [DIVR_W-1:0]         divisor_ff, rem_ff, rem_in;
   logic [QUOT_W-1:0]         dshift_ff, quot_ff;
   logic [DIVR_W:0]           trial_base, divisor_ext;
   logic                      trial_ge;
   logic signed [INC_W-1:0]   inc_ff, inc_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [INTEG_W:0]   integ_sum, ilim_pos, ilim_neg;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in, prod_ext, add_term;
   logic signed [ACC_W-1:0]   olim_pos, olim_neg;
   logic signed [ACC_W-1:0]   st_round, st_shift, cmd_round, cmd_shift;
   logic signed [CMD_W-1:0]   cmd_ff, cmd_in;
   logic signed [SPEED_W-1:0] rsp_st_ff;
   logic signed [CMD_W-1:0]   rsp_cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_kp_ff  <= OUTER_KP_RST;
         outer_kd_ff  <= OUTER_KD_RST;
         inner_kp_ff  <= INNER_KP_RST;
         inner_ki_ff  <= INNER_KI_RST;
         inner_kd_ff  <= INNER_KD_RST;
         integ_lim_ff <= INTEG_LIM_RST;
         out_lim_ff   <= OUT_LIM_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            REG_OUTER_KP:       outer_kp_ff  <= csr_wdata;
            REG_OUTER_KD:       outer_kd_ff  <= csr_wdata;
            REG_INNER_KP:       inner_kp_ff  <= csr_wdata;
            REG_INNER_KI:       inner_ki_ff  <= csr_wdata;
            REG_INNER_KD:       inner_kd_ff  <= csr_wdata;
            REG_INTEGRAL_LIMIT: integ_lim_ff <= csr_wdata[LIM_W-1:0];
            REG_OUTPUT_LIMIT:   out_lim_ff   <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // outer PD
   assign ep_in = goal_position - measured_position;
   assign dp_in = (POS_W+1)'(ep_ff) - (POS_W+1)'(oprev_ff);

   assign st_round = acc_ff + $signed({{(ACC_W-GAIN_SH){1'b0}}, {GAIN_SH{acc_ff[ACC_W-1]}}});
   assign st_shift = st_round >>> GAIN_SH;

   always_comb begin
      if (st_shift > ST_HI) begin
         st_in = SPEED_W'(ST_HI);
      end else if (st_shift < ST_LO) begin
         st_in = SPEED_W'(ST_LO);
      end else begin
         st_in = SPEED_W'(st_shift);
      end
   end

   // inner errors
   assign es_in  = ERR_W'(st_ff) - ERR_W'(ms_ff);
   assign ds_in  = DERR_W'(es_ff) - DERR_W'(iprev_ff);
   assign mag_in = es_ff[ERR_W-1] ? DIVR_W'(-es_ff) : DIVR_W'(es_ff);

   // integral rate: mag*5*2^FRAC_W / (mag+5), one quotient bit a cycle
   assign mag5        = {1'b0, mag_ff, 2'b00} + MAG5_W'(mag_ff);
   assign trial_base  = {rem_ff, dshift_ff[QUOT_W-1]};
   assign divisor_ext = {1'b0, divisor_ff};
   assign trial_ge    = trial_base >= divisor_ext;
   assign rem_in      = trial_ge ? DIVR_W'(trial_base - divisor_ext) : DIVR_W'(trial_base);

   assign inc_in = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});

   assign integ_sum = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(inc_ff);
   assign ilim_pos  = $signed((INTEG_W+1)'({integ_lim_ff, {FRAC_W{1'b0}}}));
   assign ilim_neg  = -ilim_pos;

   always_comb begin
      if (integ_sum > ilim_pos) begin
         integ_in = INTEG_W'(ilim_pos);
      end else if (integ_sum < ilim_neg) begin
         integ_in = INTEG_W'(ilim_neg);
      end else begin
         integ_in = INTEG_W'(integ_sum);
      end
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_OUT_KP: begin
            mul_a = $signed({1'b0, outer_kp_ff});
            mul_b = MUL_B_W'(ep_ff);
         end
         MUL_OUT_KD: begin
            mul_a = $signed({1'b0, outer_kd_ff});
            mul_b = MUL_B_W'(dp_ff);
         end
         MUL_IN_KP: begin
            mul_a = $signed({1'b0, inner_kp_ff});
            mul_b = MUL_B_W'(es_ff);
         end
         MUL_IN_KD: begin
            mul_a = $signed({1'b0, inner_kd_ff});
            mul_b = MUL_B_W'(ds_ff);
         end
         MUL_IN_KI: begin
            mul_a = $signed({1'b0, inner_ki_ff});
            mul_b = MUL_B_W'(integ_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // accumulator
   assign prod_ext = ACC_W'(prod_ff);
   assign add_term = cmd.acc_shift ? (prod_ext <<< FRAC_W) : prod_ext;
   assign olim_pos = $signed(ACC_W'(out_lim_ff)) <<< SCALE_SH;
   assign olim_neg = -olim_pos;

   always_comb begin
      acc_in = acc_ff;
      case (cmd.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = add_term;
         ACC_ADD:  acc_in = acc_ff + add_term;
         ACC_CLAMP: begin
            if (acc_ff > olim_pos) begin
               acc_in = olim_pos;
            end else if (acc_ff < olim_neg) begin
               acc_in = olim_neg;
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   assign cmd_round = acc_ff + $signed({{(ACC_W-SCALE_SH){1'b0}}, {SCALE_SH{acc_ff[ACC_W-1]}}});
   assign cmd_shift = cmd_round >>> SCALE_SH;
   assign cmd_in    = CMD_W'(cmd_shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         oprev_ff <= '0;
         iprev_ff <= '0;
         integ_ff <= '0;
      end else begin
         if (cmd.dp_update) oprev_ff <= ep_ff;
         if (cmd.ds_update) iprev_ff <= es_ff;
         if (cmd.integ_update) integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ep_ff <= ep_in;
         ms_ff <= measured_speed;
      end
      if (cmd.dp_update) dp_ff <= dp_in;
      if (cmd.st_update) st_ff <= st_in;
      if (cmd.es_update) es_ff <= es_in;
      if (cmd.ds_update) begin
         ds_ff  <= ds_in;
         mag_ff <= mag_in;
         neg_ff <= es_ff[ERR_W-1];
      end
      if (cmd.div_init) begin
         divisor_ff <= mag_ff + DIV_OFFSET;
         rem_ff     <= mag5[MAG5_W-1:3];
         dshift_ff  <= {mag5[2:0], {FRAC_W{1'b0}}};
         quot_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff    <= rem_in;
         dshift_ff <= {dshift_ff[QUOT_W-2:0], 1'b0};
         quot_ff   <= {quot_ff[QUOT_W-2:0], trial_ge};
      end
      if (cmd.inc_update) inc_ff <= inc_in;
      if (cmd.mul_sel != MUL_NONE) prod_ff <= prod_in;
      acc_ff <= acc_in;
      if (cmd.cmd_update) cmd_ff <= cmd_in;
      if (cmd.out_load) begin
         rsp_st_ff  <= st_ff;
         rsp_cmd_ff <= cmd_ff;
      end
   end

   assign speed_target  = rsp_st_ff;
   assign speed_command = rsp_cmd_ff;

endmodule

[design/cascade_position_speed_pid_top.sv]
// Cascade position/speed PID controller: one speed target and one speed
// command per control tick. An outer PD on position error feeds an inner
// PID on speed error whose integral grows by e*5/(|e|+5), clamped to the
// integral limit; the inner output is clamped to the output limit. Each
// item runs through the steps in turn and a new item is accepted only
// after the last one's steps are done; the steps are the one-bit-a-cycle
// restoring divider of the integral rate, passes of the single shared
// 17x33 multiplier and the accumulate, clamp and truncate steps around
// it. The result sits in an output register, so the next item is accepted
// while it waits; a stalled result holds the controller in its last step.
// Depends on csp_pkg, csp_ctrl and csp_datapath.
module cascade_position_speed_pid_top import csp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // goal_position [31:0], measured_position [63:32], measured_speed [79:64]
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // speed_target [15:0], speed_command [24:16], zero [31:25]
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type              cmd;
   logic signed [SPEED_W-1:0] speed_target;
   logic signed [CMD_W-1:0]   speed_command;

   csp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   csp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .goal_position     ($signed(req_tdata[POS_W-1:0])),
      .measured_position ($signed(req_tdata[2*POS_W-1:POS_W])),
      .measured_speed    ($signed(req_tdata[REQ_W-1:2*POS_W])),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .speed_target      (speed_target),
      .speed_command     (speed_command)
   );

   assign rsp_tdata = {{(RSP_W-SPEED_W-CMD_W){1'b0}}, speed_command, speed_target};

endmodule

[tb/sv/csp_checker.sv]
// Transfer checker for the cascade position/speed controller: keeps its own copy of the
// register settings and loop state, predicts each tick's outputs and compares them in order.
// Depends on csp_pkg.
module csp_checker import csp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    commands_due,
   output int                    fail_count
);

   localparam longint FRAC_ONE  = longint'(1) << FRAC_W;
   localparam longint SCALE_ONE = longint'(1) << SCALE_SH;
   localparam int     CMD_LSB   = SPEED_W;
   localparam int     PAD_LSB   = SPEED_W + CMD_W;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed_target;
      logic signed [CMD_W-1:0]   speed_command;
   } tick_result_type;

   longint outer_kp, outer_kd, inner_kp, inner_ki, inner_kd;
   longint integral_limit, output_limit;
   longint pos_err_prev, speed_err_prev, speed_integral;

   tick_result_type pending_commands [$];

   function automatic tick_result_type control_tick(input logic [REQ_W-1:0] d);
      logic [POS_W-1:0] pos_diff;
      longint ep, dp, st, ms, es, ds, inc, lim, acc, olim;
      tick_result_type r;
      pos_diff = d[POS_W-1:0] - d[2*POS_W-1:POS_W];
      ep = longint'($signed(pos_diff));
      dp = ep - pos_err_prev;
      pos_err_prev = ep;
      st = (outer_kp * ep + outer_kd * dp) / 256;
      if (st > 32767)
         st = 32767;
      else if (st < -32768)
         st = -32768;

      ms = longint'($signed(d[REQ_W-1:2*POS_W]));
      es = st - ms;
      ds = es - speed_err_prev;
      speed_err_prev = es;

      inc = (es * 5 * FRAC_ONE) / ((es < 0 ? -es : es) + 5);
      lim = integral_limit * FRAC_ONE;
      speed_integral = speed_integral + inc;
      if (speed_integral > lim)
         speed_integral = lim;
      if (speed_integral < -lim)
         speed_integral = -lim;

      acc = inner_kp * es * FRAC_ONE + inner_ki * speed_integral + inner_kd * ds * FRAC_ONE;
      olim = output_limit * SCALE_ONE;
      if (acc > olim)
         acc = olim;
      if (acc < -olim)
         acc = -olim;
      acc = acc / SCALE_ONE;

      r.speed_target  = st[SPEED_W-1:0];
      r.speed_command = acc[CMD_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      tick_result_type got;
      tick_result_type want;
      if (reset) begin
         outer_kp       = longint'(OUTER_KP_RST);
         outer_kd       = longint'(OUTER_KD_RST);
         inner_kp       = longint'(INNER_KP_RST);
         inner_ki       = longint'(INNER_KI_RST);
         inner_kd       = longint'(INNER_KD_RST);
         integral_limit = longint'(INTEG_LIM_RST);
         output_limit   = longint'(OUT_LIM_RST);
         pos_err_prev   = 0;
         speed_err_prev = 0;
         speed_integral = 0;
         fail_count     = 0;
         pending_commands.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_OUTER_KP:       outer_kp = longint'(csr_wdata);
               REG_OUTER_KD:       outer_kd = longint'(csr_wdata);
               REG_INNER_KP:       inner_kp = longint'(csr_wdata);
               REG_INNER_KI:       inner_ki = longint'(csr_wdata);
               REG_INNER_KD:       inner_kd = longint'(csr_wdata);
               REG_INTEGRAL_LIMIT: integral_limit = longint'(csr_wdata[LIM_W-1:0]);
               REG_OUTPUT_LIMIT:   output_limit = longint'(csr_wdata[LIM_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.speed_target  = rsp_tdata[SPEED_W-1:0];
            got.speed_command = rsp_tdata[PAD_LSB-1:CMD_LSB];
            if (pending_commands.size() == 0) begin
               $display("%0t unexpected transfer: expected none, got target %0d command %0d",
                        $time, got.speed_target, got.speed_command);
               fail_count++;
            end else begin
               want = pending_commands.pop_front();
               if (got.speed_target !== want.speed_target) begin
                  $display("%0t speed_target: expected %0d, got %0d",
                           $time, want.speed_target, got.speed_target);
                  fail_count++;
               end
               if (got.speed_command !== want.speed_command) begin
                  $display("%0t speed_command: expected %0d, got %0d",
                           $time, want.speed_command, got.speed_command);
                  fail_count++;
               end
               if (rsp_tdata[RSP_W-1:PAD_LSB] !== '0) begin
                  $display("%0t padding: expected 0, got %0h",
                           $time, rsp_tdata[RSP_W-1:PAD_LSB]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_commands.push_back(control_tick(req_tdata));
      end
      commands_due <= pending_commands.size();
   end

endmodule

[tb/sv/cascade_position_speed_pid_top_tb.sv]
// Testbench top for the cascade position/speed controller: clock, reset, register
// settings and control ticks with random idling; csp_checker predicts and compares.
// Depends on csp_pkg, csp_checker and cascade_position_speed_pid_top.
module cascade_position_speed_pid_top_tb;
   import csp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int NUM_REGS        = 7;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PHASES   = 11;
   localparam int PHASE_TICKS     = 50;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int commands_due;
   int fail_count;
   int send_idle_pct = 8;
   int recv_idle_pct = 60;
   bit hold_off_request = 1'b0;
   logic [POS_W-1:0] travel = '0;
   logic [CSR_DATA_W-1:0] reg_value [NUM_REGS];

   cascade_position_speed_pid_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   csp_checker chk (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .commands_due (commands_due),
      .fail_count   (fail_count)
   );

   always #5 clock = ~clock;

   function automatic logic [REQ_W-1:0] pack_tick(input logic [POS_W-1:0] tp,
                                                  input logic [POS_W-1:0] mp,
                                                  input logic [SPEED_W-1:0] ms);
      return {ms, mp, tp};
   endfunction

   function automatic logic [REQ_W-1:0] random_tick();
      logic [POS_W-1:0] tp;
      logic [POS_W-1:0] err;
      logic [SPEED_W-1:0] ms;
      int sel;
      sel = $urandom_range(0, 99);
      travel = travel + $urandom_range(0, 40);
      tp = travel;
      ms = SPEED_W'($urandom());
      if (sel < 55) begin
         err = $urandom_range(0, 600) - 300;
         ms = SPEED_W'($urandom_range(0, 400) - 200);
      end else if (sel < 75) begin
         err = $urandom_range(0, 131072) - 65536;
         ms = SPEED_W'($urandom_range(0, 4000) - 2000);
      end else if (sel < 90) begin
         tp = $urandom();
         err = $urandom();
      end else begin
         tp = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         err = $urandom_range(0, 1) ? tp + 32'h8000_0001 : tp;
      end
      return pack_tick(tp, tp - err, ms);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_gain();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return '0;
      if (sel == 1)
         return '1;
      if (sel < 7)
         return CSR_DATA_W'($urandom_range(0, 512));
      return CSR_DATA_W'($urandom());
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_limit();
      logic [31:0] noise;
      int sel;
      noise = $urandom();
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return {noise[7:0], 8'd0};
      if (sel == 1)
         return {noise[7:0], 8'hFF};
      return {noise[7:0], 8'($urandom_range(1, 60))};
   endfunction

   task automatic apply_settings();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= reg_value[i];
         @(posedge clock);
      end
      csr_index <= REG_UNUSED;
      csr_wdata <= CSR_DATA_W'($urandom());
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_tick(input logic [REQ_W-1:0] d, input bit last);
      int gap;
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (last || gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained(input int settle);
      do @(posedge clock); while (commands_due != 0);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      bit last;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: wrap, saturation, truncation, integral clamp
      send_tick(pack_tick(32'd0, 32'd0, 16'd0), 1'b0);
      send_tick(pack_tick(32'h7FFF_FFFF, 32'h8000_0000, 16'd0), 1'b0);
      send_tick(pack_tick(32'h8000_0000, 32'h7FFF_FFFF, 16'd0), 1'b0);
      send_tick(pack_tick(32'h7FFF_FFFF, 32'd0, 16'h7FFF), 1'b0);
      send_tick(pack_tick(32'h8000_0000, 32'd0, 16'h8000), 1'b0);
      send_tick(pack_tick(32'd100, 32'd0, 16'h7FFF), 1'b0);
      send_tick(pack_tick(-32'sd100, 32'd0, 16'h8000), 1'b0);
      send_tick(pack_tick(32'd3, 32'd0, 16'd0), 1'b0);
      send_tick(pack_tick(-32'sd3, 32'd0, 16'd0), 1'b0);
      repeat (4) send_tick(pack_tick(32'd1000, 32'd0, 16'hFFFF), 1'b0);
      send_tick(pack_tick(32'd0, 32'd1000, 16'd5), 1'b1);
      wait_drained(SETTLE_CYCLES);

      // every gain and limit at its top value
      for (int i = 0; i < NUM_REGS; i++)
         reg_value[i] = '1;
      apply_settings();
      send_tick(pack_tick(32'd0, 32'd0, 16'd0), 1'b0);
      send_tick(pack_tick(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000), 1'b0);
      send_tick(pack_tick(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF), 1'b0);
      send_tick(pack_tick(32'd1, 32'd0, 16'h7FFF), 1'b0);
      send_tick(pack_tick(32'd0, 32'd1, 16'h8000), 1'b0);
      send_tick(pack_tick(32'd7, 32'd0, 16'd0), 1'b1);
      wait_drained(SETTLE_CYCLES);

      // zero gains and limits force zero outputs
      for (int i = 0; i < NUM_REGS; i++)
         reg_value[i] = '0;
      apply_settings();
      send_tick(pack_tick(32'h7FFF_FFFF, 32'd0, 16'h8000), 1'b0);
      send_tick(pack_tick(32'h8000_0000, 32'd0, 16'h7FFF), 1'b0);
      send_tick(pack_tick(32'd500, 32'd0, 16'd0), 1'b0);
      send_tick(pack_tick(32'd0, 32'd0, 16'hFFFF), 1'b1);
      wait_drained(SETTLE_CYCLES);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 4) begin
            send_idle_pct = 8;
            recv_idle_pct = 60;
         end else if (p < 8) begin
            send_idle_pct = 60;
            recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int r = REG_OUTER_KP; r <= REG_INNER_KD; r++)
            reg_value[r] = random_gain();
         reg_value[REG_INTEGRAL_LIMIT] = random_limit();
         reg_value[REG_OUTPUT_LIMIT]   = random_limit();
         apply_settings();
         for (int i = 0; i < PHASE_TICKS; i++) begin
            // long result hold-off fills the block and stalls its input
            if (p == 1 && i == 10)
               hold_off_request = 1'b1;
            last = (i == PHASE_TICKS - 1) || (p == 5 && i == PHASE_TICKS / 2);
            send_tick(random_tick(), last);
            if (p == 5 && i == PHASE_TICKS / 2)
               wait_drained(0);
         end
         wait_drained(SETTLE_CYCLES);
      end

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
design/csp_pkg.sv
design/csp_ctrl.sv
design/csp_datapath.sv
design/cascade_position_speed_pid_top.sv
tb/sv/csp_checker.sv
tb/sv/cascade_position_speed_pid_top_tb.sv
